>>> hdl/vsrd_pkg.sv
`default_nettype none

package vsrd_pkg;

  // parse phases, one-hot
  typedef enum logic [14:0] {
    PH_HDR   = 15'h0001,
    PH_GEN   = 15'h0002,
    PH_VERT  = 15'h0004,
    PH_SX    = 15'h0008,
    PH_SY    = 15'h0010,
    PH_CX    = 15'h0020,
    PH_CY    = 15'h0040,
    PH_AX    = 15'h0080,
    PH_AY    = 15'h0100,
    PH_MBITS = 15'h0200,
    PH_MX    = 15'h0400,
    PH_MY    = 15'h0800,
    PH_F0    = 15'h1000,
    PH_F1    = 15'h2000,
    PH_LS    = 15'h4000
  } phase_e;

  typedef enum logic [2:0] {
    KIND_STRAIGHT   = 3'd0,
    KIND_CURVED     = 3'd1,
    KIND_STYLE      = 3'd2,
    KIND_END        = 3'd3,
    KIND_NEW_STYLES = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_FILL_BITS = 3'd0,
    CFG_LINE_BITS = 3'd1,
    CFG_FILL_BASE = 3'd2,
    CFG_LINE_BASE = 3'd3
  } cfg_idx_e;

  localparam int unsigned CfgIdxWidth = 3;

  // record flag bit positions
  localparam int unsigned FbMove     = 0;
  localparam int unsigned FbFill0    = 1;
  localparam int unsigned FbFill1    = 2;
  localparam int unsigned FbLine     = 3;
  localparam int unsigned FbNew      = 4;  // new styles (style change) / straight (edge)
  localparam int unsigned FbHoriz    = 5;  // internal: horizontal-only line
  localparam int unsigned FbEdge     = 5;  // header bit: edge record

  localparam logic [4:0] HdrBits   = 5'd6;
  localparam logic [4:0] MoveBitsW = 5'd5;

  typedef struct packed {
    logic [3:0]  fill_bits;
    logic [3:0]  line_bits;
    logic [15:0] fill_base;
    logic [15:0] line_base;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  bits_left;
    logic [4:0]  width;
    logic [31:0] acc;
    logic [5:0]  flags;
    logic [14:0] pend0;
    logic [14:0] pend1;
    logic [14:0] pends;
    logic        done;
  } parse_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [15:0]        f0_idx;
    logic               f0_v;
    logic [15:0]        f1_idx;
    logic               f1_v;
    logic [15:0]        s_idx;
    logic               s_v;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/vsrd_bit_step.sv
`default_nettype none

// One stream bit: shift into the current field, complete it if full.
// Zero-width style fields are folded into the completion.
module vsrd_bit_step #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                   en_i,
  input  wire logic                   bit_i,
  input  wire vsrd_pkg::cfg_t         cfg_i,
  input  wire vsrd_pkg::parse_t       ps_i,
  input  wire logic [COORD_WIDTH-1:0] pen_x_i,
  input  wire logic [COORD_WIDTH-1:0] pen_y_i,
  input  wire logic [COORD_WIDTH-1:0] dx_i,
  input  wire logic [COORD_WIDTH-1:0] dy_i,
  output vsrd_pkg::parse_t            ps_o,
  output logic [COORD_WIDTH-1:0]      pen_x_o,
  output logic [COORD_WIDTH-1:0]      pen_y_o,
  output logic [COORD_WIDTH-1:0]      dx_o,
  output logic [COORD_WIDTH-1:0]      dy_o,
  output logic                        emit_o,
  output vsrd_pkg::res_t              res_o,
  output logic                        stop_o
);
  import vsrd_pkg::*;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  function automatic parse_t begin_f(parse_t p, phase_e ph, logic [4:0] w);
    parse_t r;
    r = p;
    r.phase = ph;
    r.width = w;
    r.bits_left = w;
    r.acc = '0;
    return r;
  endfunction

  function automatic logic [31:0] sext_f(logic [31:0] x, logic [4:0] w);
    logic [31:0] r;
    r = x;
    if (w == '0) begin
      r = '0;
    end else if (x[w - 5'd1]) begin
      r = x | (32'hFFFF_FFFF << w);
    end
    return r;
  endfunction

  function automatic res_t mk_res(kind_e k, coord_t ax, coord_t ay, coord_t cx, coord_t cy);
    res_t r;
    r = '0;
    r.kind = k;
    r.ax = 32'(signed'(ax));
    r.ay = 32'(signed'(ay));
    r.cx = 32'(signed'(cx));
    r.cy = 32'(signed'(cy));
    return r;
  endfunction

  parse_t      p;
  coord_t      px, py, dx, dy, sc;
  logic [31:0] v, s;
  logic [4:0]  n, n_hdr;
  logic        do_style;
  logic [2:0]  st;

  always_comb begin
    p = ps_i;
    px = pen_x_i;
    py = pen_y_i;
    dx = dx_i;
    dy = dy_i;
    emit_o = 1'b0;
    stop_o = 1'b0;
    res_o = '0;
    do_style = 1'b0;
    st = '0;
    v = '0;
    s = '0;
    sc = '0;
    n = '0;
    n_hdr = '0;
    if (en_i) begin
      if (p.bits_left == '0) p = begin_f(p, PH_HDR, HdrBits);
      p.acc = {p.acc[30:0], bit_i};
      p.bits_left = p.bits_left - 5'd1;
      if (p.bits_left == '0) begin
        v = p.acc;
        s = sext_f(v, p.width);
        sc = s[COORD_WIDTH-1:0];
        n = {1'b0, p.flags[3:0]} + 5'd2;
        n_hdr = {1'b0, v[3:0]} + 5'd2;
        case (p.phase)
          PH_HDR: begin
            p.flags = {1'b0, v[4:0]};
            if (v[FbEdge]) begin
              if (v[FbNew]) p = begin_f(p, PH_GEN, 5'd1);
              else p = begin_f(p, PH_CX, n_hdr);
            end else if (v[4:0] == '0) begin
              emit_o = 1'b1;
              res_o = mk_res(KIND_END, px, py, px, py);
              p.done = 1'b1;
              p = begin_f(p, PH_HDR, HdrBits);
              stop_o = 1'b1;
            end else begin
              p.pend0 = '0;
              p.pend1 = '0;
              p.pends = '0;
              do_style = 1'b1;
              st = 3'd0;
            end
          end
          PH_GEN: begin
            if (v[0]) p = begin_f(p, PH_SX, n);
            else p = begin_f(p, PH_VERT, 5'd1);
          end
          PH_VERT: begin
            if (v[0]) begin
              dx = '0;
              p = begin_f(p, PH_SY, n);
            end else begin
              p.flags[FbHoriz] = 1'b1;
              p = begin_f(p, PH_SX, n);
            end
          end
          PH_SX: begin
            dx = sc;
            if (p.flags[FbHoriz]) begin
              px = px + sc;
              emit_o = 1'b1;
              res_o = mk_res(KIND_STRAIGHT, px, py, px, py);
              p = begin_f(p, PH_HDR, HdrBits);
            end else begin
              p = begin_f(p, PH_SY, n);
            end
          end
          PH_SY: begin
            px = px + dx;
            py = py + sc;
            emit_o = 1'b1;
            res_o = mk_res(KIND_STRAIGHT, px, py, px, py);
            p = begin_f(p, PH_HDR, HdrBits);
          end
          PH_CX: begin
            dx = px + sc;
            p = begin_f(p, PH_CY, n);
          end
          PH_CY: begin
            dy = py + sc;
            p = begin_f(p, PH_AX, n);
          end
          PH_AX: begin
            px = dx + sc;
            p = begin_f(p, PH_AY, n);
          end
          PH_AY: begin
            py = dy + sc;
            emit_o = 1'b1;
            res_o = mk_res(KIND_CURVED, px, py, dx, dy);
            p = begin_f(p, PH_HDR, HdrBits);
          end
          PH_MBITS: begin
            if (v[4:0] == '0) begin
              // zero-width move: both coordinates read as 0
              dx = '0;
              px = '0;
              py = '0;
              do_style = 1'b1;
              st = 3'd1;
            end else begin
              p = begin_f(p, PH_MX, v[4:0]);
            end
          end
          PH_MX: begin
            dx = sc;
            p = begin_f(p, PH_MY, p.width);
          end
          PH_MY: begin
            px = dx;
            py = sc;
            do_style = 1'b1;
            st = 3'd1;
          end
          PH_F0: begin
            p.pend0 = v[14:0];
            do_style = 1'b1;
            st = 3'd2;
          end
          PH_F1: begin
            p.pend1 = v[14:0];
            do_style = 1'b1;
            st = 3'd3;
          end
          PH_LS: begin
            p.pends = v[14:0];
            do_style = 1'b1;
            st = 3'd4;
          end
          default: begin
            p = begin_f(p, PH_HDR, HdrBits);
          end
        endcase

        // next style-change field; zero-width index fields are skipped
        if (do_style) begin
          if (st == 3'd0 && p.flags[FbMove]) begin
            p = begin_f(p, PH_MBITS, MoveBitsW);
          end else if (st <= 3'd1 && p.flags[FbFill0] && cfg_i.fill_bits != '0) begin
            p = begin_f(p, PH_F0, {1'b0, cfg_i.fill_bits});
          end else if (st <= 3'd2 && p.flags[FbFill1] && cfg_i.fill_bits != '0) begin
            p = begin_f(p, PH_F1, {1'b0, cfg_i.fill_bits});
          end else if (st <= 3'd3 && p.flags[FbLine] && cfg_i.line_bits != '0) begin
            p = begin_f(p, PH_LS, {1'b0, cfg_i.line_bits});
          end else begin
            emit_o = 1'b1;
            res_o = mk_res(p.flags[FbNew] ? KIND_NEW_STYLES : KIND_STYLE, px, py, px, py);
            if (p.flags[FbFill0]) begin
              res_o.f0_idx = {1'b0, p.pend0} + cfg_i.fill_base;
              res_o.f0_v = 1'b1;
            end
            if (p.flags[FbFill1]) begin
              res_o.f1_idx = {1'b0, p.pend1} + cfg_i.fill_base;
              res_o.f1_v = 1'b1;
            end
            if (p.flags[FbLine]) begin
              res_o.s_idx = {1'b0, p.pends} + cfg_i.line_base;
              res_o.s_v = 1'b1;
            end
            stop_o = p.flags[FbNew];
            p = begin_f(p, PH_HDR, HdrBits);
          end
        end
      end
    end
    ps_o = p;
    pen_x_o = px;
    pen_y_o = py;
    dx_o = dx;
    dy_o = dy;
  end

endmodule

`default_nettype wire

>>> hdl/vector_shape_record_decoder.sv
`default_nettype none

// Channel   Direction  Handshake              Beat
// in        input      in_valid_i/in_ready_o  data_byte_i, shape_start_i
// out       output     out_valid_o/out_ready_i record_kind_o .. last_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte beat per cycle while in_ready_o is high: the eight bits are parsed
// combinationally by a chain of eight bit-step slices; a byte gives zero, one or
// two result beats. Results go into a 4-entry queue; in_ready_o is high while two
// entries are free, so a byte stalls only behind an output that is not drained.
// Reset clears pen, parse state, registers and queue; no clearing pass.
// cfg_ready_o is always high.
module vector_shape_record_decoder #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [7:0]                           data_byte_i,
  input  wire logic                                 shape_start_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [2:0]                                record_kind_o,
  output logic signed [31:0]                        anchor_x_o,
  output logic signed [31:0]                        anchor_y_o,
  output logic signed [31:0]                        control_x_o,
  output logic signed [31:0]                        control_y_o,
  output logic [15:0]                               fill0_index_o,
  output logic                                      fill0_valid_o,
  output logic [15:0]                               fill1_index_o,
  output logic                                      fill1_valid_o,
  output logic [15:0]                               stroke_index_o,
  output logic                                      stroke_valid_o,
  output logic                                      last_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [vsrd_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [15:0]                          cfg_data_i
);
  import vsrd_pkg::*;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef logic [COORD_WIDTH-1:0] coord_t;

  cfg_t   cfg_q;
  parse_t ps_q, ps_start;
  coord_t pen_x_q, pen_y_q, dx_q, dy_q;
  coord_t pen_x_s, pen_y_s, dx_s, dy_s;

  parse_t ps_w    [9];
  coord_t px_w    [9];
  coord_t py_w    [9];
  coord_t dx_w    [9];
  coord_t dy_w    [9];
  logic   en_w    [9];
  logic   emit_w  [8];
  logic   stop_w  [8];
  res_t   res_w   [8];

  res_t       r0, r1;
  logic [1:0] nres;

  res_t          q_data [QDepth];
  logic          q_last [QDepth];
  logic [QAw-1:0] wptr_q, rptr_q;
  logic [QAw:0]   count_q;
  logic           accept, pop;
  logic [1:0]     push_n;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FILL_BITS: cfg_q.fill_bits <= cfg_data_i[3:0];
        CFG_LINE_BITS: cfg_q.line_bits <= cfg_data_i[3:0];
        CFG_FILL_BASE: cfg_q.fill_base <= cfg_data_i;
        CFG_LINE_BASE: cfg_q.line_base <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shape start clears the pen and parse state before the byte is parsed
  always_comb begin
    ps_start = ps_q;
    pen_x_s = pen_x_q;
    pen_y_s = pen_y_q;
    dx_s = dx_q;
    dy_s = dy_q;
    if (shape_start_i) begin
      ps_start = '0;
      ps_start.phase = PH_HDR;
      ps_start.width = HdrBits;
      ps_start.bits_left = HdrBits;
      pen_x_s = '0;
      pen_y_s = '0;
      dx_s = '0;
      dy_s = '0;
    end
  end

  assign ps_w[0] = ps_start;
  assign px_w[0] = pen_x_s;
  assign py_w[0] = pen_y_s;
  assign dx_w[0] = dx_s;
  assign dy_w[0] = dy_s;
  assign en_w[0] = ~ps_start.done;

  for (genvar i = 0; i < 8; i++) begin : g_bit
    vsrd_bit_step #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_step (
      .en_i   (en_w[i]),
      .bit_i  (data_byte_i[7-i]),
      .cfg_i  (cfg_q),
      .ps_i   (ps_w[i]),
      .pen_x_i(px_w[i]),
      .pen_y_i(py_w[i]),
      .dx_i   (dx_w[i]),
      .dy_i   (dy_w[i]),
      .ps_o   (ps_w[i+1]),
      .pen_x_o(px_w[i+1]),
      .pen_y_o(py_w[i+1]),
      .dx_o   (dx_w[i+1]),
      .dy_o   (dy_w[i+1]),
      .emit_o (emit_w[i]),
      .res_o  (res_w[i]),
      .stop_o (stop_w[i])
    );
    assign en_w[i+1] = en_w[i] & ~stop_w[i];
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    nres = '0;
    for (int i = 0; i < 8; i++) begin
      if (emit_w[i]) begin
        if (nres == 2'd0) r0 = res_w[i];
        else if (nres == 2'd1) r1 = res_w[i];
        if (nres != 2'd2) nres = nres + 2'd1;
      end
    end
  end

  assign in_ready_o = (count_q <= (QAw+1)'(QDepth - 2));
  assign accept = in_valid_i & in_ready_o;
  assign pop = out_valid_o & out_ready_i;
  assign push_n = accept ? nres : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= '0;
      ps_q.phase <= PH_HDR;
      ps_q.width <= HdrBits;
      ps_q.bits_left <= HdrBits;
      pen_x_q <= '0;
      pen_y_q <= '0;
      dx_q <= '0;
      dy_q <= '0;
    end else if (accept) begin
      ps_q <= ps_w[8];
      pen_x_q <= px_w[8];
      pen_y_q <= py_w[8];
      dx_q <= dx_w[8];
      dy_q <= dy_w[8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      wptr_q <= wptr_q + QAw'(push_n);
      rptr_q <= rptr_q + QAw'(pop);
      count_q <= count_q + (QAw+1)'(push_n) - (QAw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_data[wptr_q] <= r0;
      q_last[wptr_q] <= (push_n == 2'd1);
    end
    if (push_n == 2'd2) begin
      q_data[wptr_q + QAw'(1)] <= r1;
      q_last[wptr_q + QAw'(1)] <= 1'b1;
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign record_kind_o  = q_data[rptr_q].kind;
  assign anchor_x_o     = q_data[rptr_q].ax;
  assign anchor_y_o     = q_data[rptr_q].ay;
  assign control_x_o    = q_data[rptr_q].cx;
  assign control_y_o    = q_data[rptr_q].cy;
  assign fill0_index_o  = q_data[rptr_q].f0_idx;
  assign fill0_valid_o  = q_data[rptr_q].f0_v;
  assign fill1_index_o  = q_data[rptr_q].f1_idx;
  assign fill1_valid_o  = q_data[rptr_q].f1_v;
  assign stroke_index_o = q_data[rptr_q].s_idx;
  assign stroke_valid_o = q_data[rptr_q].s_v;
  assign last_o         = q_last[rptr_q];

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QAw+1)'(QDepth))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + (QAw+1)'($past(push_n)) - (QAw+1)'($past(pop)))
    else $error("queue count out of step with push/pop");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !last_o) |=> out_valid_o)
    else $error("second result of a byte missing");

  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ps_q.done && !shape_start_i) |-> nres == 2'd0)
    else $error("result after end of shape");

endmodule

`default_nettype wire
